// ===== src/bnpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bnpf_pkg: shared types and helpers for the bimatrix Nash/Pareto finder
// Sizes, payoff and index types, controller states and datapath commands.
// ----------------------------------------------------------------------------
package bnpf_pkg;

  localparam int MAX_STRATEGIES = 8;
  localparam int PAYOFF_WIDTH   = 16;
  localparam int CELLS          = MAX_STRATEGIES * MAX_STRATEGIES;
  localparam int IDX_W          = $clog2(MAX_STRATEGIES);
  localparam int ADDR_W         = $clog2(CELLS);
  localparam int CFG_W          = 4;
  localparam int IN_IDX_W       = 3;
  localparam int IN_PAYOFF_W    = 16;

  typedef logic [IDX_W-1:0]               idx_t;
  typedef logic [ADDR_W-1:0]              addr_t;
  typedef logic signed [PAYOFF_WIDTH-1:0] payoff_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COLMAX,
    ST_ROWMAX,
    ST_TARGET,
    ST_SCAN,
    ST_WAIT,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_COLMAX,
    OP_ROWMAX,
    OP_TARGET,
    OP_SCAN
  } op_t;

  typedef struct packed {
    logic wr_en;
    op_t  op;
    logic first;
    logic last;
    idx_t row;
    idx_t col;
    idx_t tgt_row;
    idx_t tgt_col;
  } dp_cmd_t;

  typedef struct packed {
    logic nash;
    logic pareto;
  } dp_stat_t;

  function automatic payoff_t payoff_in(logic signed [IN_PAYOFF_W-1:0] v);
    return payoff_t'(v);
  endfunction

  function automatic addr_t cell_addr(idx_t r, idx_t c);
    return addr_t'(int'(r) * MAX_STRATEGIES + int'(c));
  endfunction

  // clamps a size code to 1..MAX_STRATEGIES and returns the last index
  function automatic idx_t last_index(logic [CFG_W-1:0] v);
    if (v == '0) begin
      return '0;
    end else if (int'(v) > MAX_STRATEGIES) begin
      return idx_t'(MAX_STRATEGIES - 1);
    end else begin
      return idx_t'(int'(v) - 1);
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/bimatrix_nash_pareto_finder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bimatrix_nash_pareto_finder_top: pure Nash and Pareto cell finder
// Loads a square bimatrix game cell by cell, then reports one flag
// result per cell in row-major order.
//
//   channel  ports                      transfer when
//   in       in_valid / in_stall        in_valid & !in_stall
//   out      out_valid / out_stall      out_valid & !out_stall
//   cfg      cfg_we / cfg_wdata         cfg_we
//
// A cell without last_cell is stored and leaves the input open. A
// last_cell item then runs a column-wise and a row-wise max search,
// and for each result a target read, scan reads of every cell through
// the single read port of each store, a wait state and an output state.
// Output stalls hold the result and extend the run. Reset gives size 8
// and best-reply tables cleared to zero; payoff stores hold nothing until written.
// ----------------------------------------------------------------------------
module bimatrix_nash_pareto_finder_top
  import bnpf_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_W-1:0]              cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [IN_IDX_W-1:0]           in_row,
  input  wire logic [IN_IDX_W-1:0]           in_col,
  input  wire logic signed [IN_PAYOFF_W-1:0] in_payoff_row_player,
  input  wire logic signed [IN_PAYOFF_W-1:0] in_payoff_col_player,
  input  wire logic                          in_last_cell,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [IN_IDX_W-1:0]                out_cell_row,
  output logic [IN_IDX_W-1:0]                out_cell_col,
  output logic                               out_is_nash,
  output logic                               out_is_pareto,
  output logic                               out_last_result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bnpf_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_last_cell    (in_last_cell),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cell_row    (out_cell_row),
    .out_cell_col    (out_cell_col),
    .out_last_result (out_last_result),
    .cmd             (cmd)
  );

  bnpf_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_row               (in_row),
    .in_col               (in_col),
    .in_payoff_row_player (in_payoff_row_player),
    .in_payoff_col_player (in_payoff_col_player),
    .stat                 (stat)
  );

  assign out_is_nash   = stat.nash;
  assign out_is_pareto = stat.pareto;

  a_no_load_while_out : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result is pending");

  a_last_starts_run : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_cell |=> in_stall && !out_valid)
    else $error("analysis did not start after last cell");

  a_load_one_cycle : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last_cell |=> !in_stall)
    else $error("plain load did not return to idle");

  a_run_ends : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_result |=> !out_valid && !in_stall)
    else $error("run did not end after final result");

endmodule
`default_nettype wire

// ===== src/bnpf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bnpf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bnpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== src/bnpf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bnpf_ctrl: sequencing controller
// Holds the size register, walks the max searches and the per-cell
// dominance scans, and presents each result.
// ----------------------------------------------------------------------------
module bnpf_ctrl
  import bnpf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  input  wire logic                in_valid,
  input  wire logic                in_last_cell,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [IN_IDX_W-1:0]      out_cell_row,
  output logic [IN_IDX_W-1:0]      out_cell_col,
  output logic                     out_last_result,
  output dp_cmd_t                  cmd
);

  state_t state_r, state_nxt;
  idx_t   nl_r;
  idx_t   cr_r, cr_nxt;
  idx_t   cc_r, cc_nxt;
  idx_t   ci_r, ci_nxt;
  idx_t   cj_r, cj_nxt;
  logic   cell_end;

  assign cell_end = (ci_r == nl_r) && (cj_r == nl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      nl_r    <= idx_t'(MAX_STRATEGIES - 1);
      cr_r    <= '0;
      cc_r    <= '0;
      ci_r    <= '0;
      cj_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cr_r    <= cr_nxt;
      cc_r    <= cc_nxt;
      ci_r    <= ci_nxt;
      cj_r    <= cj_nxt;
      if (cfg_we) begin
        nl_r <= last_index(cfg_wdata);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cr_nxt      = cr_r;
    cc_nxt      = cc_r;
    ci_nxt      = ci_r;
    cj_nxt      = cj_r;
    cmd         = '0;
    cmd.op      = OP_NONE;
    cmd.tgt_row = ci_r;
    cmd.tgt_col = cj_r;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.wr_en  = in_valid;
        if (in_valid && in_last_cell) begin
          state_nxt = ST_COLMAX;
          cr_nxt    = '0;
          cc_nxt    = '0;
          ci_nxt    = '0;
          cj_nxt    = '0;
        end
      end
      ST_COLMAX: begin
        // column-wise sweep, row index inner
        cmd.op    = OP_COLMAX;
        cmd.row   = cr_r;
        cmd.col   = cc_r;
        cmd.first = (cr_r == '0);
        cmd.last  = (cr_r == nl_r);
        if (cr_r == nl_r) begin
          cr_nxt = '0;
          if (cc_r == nl_r) begin
            cc_nxt    = '0;
            state_nxt = ST_ROWMAX;
          end else begin
            cc_nxt = cc_r + idx_t'(1);
          end
        end else begin
          cr_nxt = cr_r + idx_t'(1);
        end
      end
      ST_ROWMAX, ST_SCAN: begin
        cmd.op    = (state_r == ST_ROWMAX) ? OP_ROWMAX : OP_SCAN;
        cmd.row   = cr_r;
        cmd.col   = cc_r;
        cmd.first = (cc_r == '0);
        cmd.last  = (cc_r == nl_r);
        if (cc_r == nl_r) begin
          cc_nxt = '0;
          if (cr_r == nl_r) begin
            cr_nxt    = '0;
            state_nxt = (state_r == ST_ROWMAX) ? ST_TARGET : ST_WAIT;
          end else begin
            cr_nxt = cr_r + idx_t'(1);
          end
        end else begin
          cc_nxt = cc_r + idx_t'(1);
        end
      end
      ST_TARGET: begin
        cmd.op    = OP_TARGET;
        cmd.row   = ci_r;
        cmd.col   = cj_r;
        state_nxt = ST_SCAN;
      end
      ST_WAIT: begin
        // last scan read still in flight
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (cell_end) begin
            ci_nxt    = '0;
            cj_nxt    = '0;
            state_nxt = ST_IDLE;
          end else begin
            if (cj_r == nl_r) begin
              cj_nxt = '0;
              ci_nxt = ci_r + idx_t'(1);
            end else begin
              cj_nxt = cj_r + idx_t'(1);
            end
            state_nxt = ST_TARGET;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_cell_row    = IN_IDX_W'(ci_r);
  assign out_cell_col    = IN_IDX_W'(cj_r);
  assign out_last_result = cell_end;

endmodule
`default_nettype wire

// ===== src/bnpf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bnpf_datapath: payoff stores, max search and dominance check
// Two payoff RAMs, a running maximum, best-reply tables and the
// dominance flag for the cell under test.
// ----------------------------------------------------------------------------
module bnpf_datapath
  import bnpf_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dp_cmd_t                       cmd,
  input  wire logic [IN_IDX_W-1:0]           in_row,
  input  wire logic [IN_IDX_W-1:0]           in_col,
  input  wire logic signed [IN_PAYOFF_W-1:0] in_payoff_row_player,
  input  wire logic signed [IN_PAYOFF_W-1:0] in_payoff_col_player,
  output dp_stat_t                           stat
);

  dp_cmd_t pipe_r;
  logic    wr;
  addr_t   waddr;
  addr_t   raddr;
  payoff_t rd_a;
  payoff_t rd_b;
  payoff_t run_max_r;
  idx_t    run_idx_r;
  payoff_t tgt_a_r;
  payoff_t tgt_b_r;
  logic    dom_r;
  idx_t    best_row_r [MAX_STRATEGIES];
  idx_t    best_col_r [MAX_STRATEGIES];
  logic    use_b;
  payoff_t cmp_val;
  idx_t    cmp_idx;
  logic    take;
  logic    self_cell;
  logic    dominated;

  assign wr    = cmd.wr_en && (int'(in_row) < MAX_STRATEGIES)
                           && (int'(in_col) < MAX_STRATEGIES);
  assign waddr = cell_addr(idx_t'(in_row), idx_t'(in_col));
  assign raddr = cell_addr(cmd.row, cmd.col);

  bnpf_ram #(.WIDTH(PAYOFF_WIDTH), .DEPTH(CELLS)) u_row_store (
    .clk   (clk),
    .we    (wr),
    .waddr (waddr),
    .wdata (payoff_in(in_payoff_row_player)),
    .raddr (raddr),
    .rdata (rd_a)
  );

  bnpf_ram #(.WIDTH(PAYOFF_WIDTH), .DEPTH(CELLS)) u_col_store (
    .clk   (clk),
    .we    (wr),
    .waddr (waddr),
    .wdata (payoff_in(in_payoff_col_player)),
    .raddr (raddr),
    .rdata (rd_b)
  );

  assign use_b     = (pipe_r.op == OP_ROWMAX);
  assign cmp_val   = use_b ? rd_b : rd_a;
  assign cmp_idx   = use_b ? pipe_r.col : pipe_r.row;
  assign take      = pipe_r.first || (cmp_val > run_max_r);
  assign self_cell = (pipe_r.row == cmd.tgt_row) && (pipe_r.col == cmd.tgt_col);
  assign dominated = !self_cell && (rd_a >= tgt_a_r) && (rd_b >= tgt_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r <= '0;
      for (int k = 0; k < MAX_STRATEGIES; k++) begin
        best_row_r[k] <= '0;
        best_col_r[k] <= '0;
      end
    end else begin
      pipe_r <= cmd;
      if (pipe_r.last && (pipe_r.op == OP_COLMAX)) begin
        best_row_r[pipe_r.col] <= take ? cmp_idx : run_idx_r;
      end
      if (pipe_r.last && (pipe_r.op == OP_ROWMAX)) begin
        best_col_r[pipe_r.row] <= take ? cmp_idx : run_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (pipe_r.op)
      OP_COLMAX, OP_ROWMAX: begin
        if (take) begin
          run_max_r <= cmp_val;
          run_idx_r <= cmp_idx;
        end
      end
      OP_TARGET: begin
        tgt_a_r <= rd_a;
        tgt_b_r <= rd_b;
        dom_r   <= 1'b0;
      end
      OP_SCAN: begin
        if (dominated) begin
          dom_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.nash   = (best_row_r[cmd.tgt_col] == cmd.tgt_row)
                    && (best_col_r[cmd.tgt_row] == cmd.tgt_col);
  assign stat.pareto = !dom_r;

endmodule
`default_nettype wire

// ===== bench/bnpf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnpf_checker: flag predictor and result checker for the Nash/Pareto finder
// Watches the cfg, in and out channels. Keeps its own payoff board and size,
// works out the per-cell Nash and Pareto flags on every last_cell transfer
// and compares each out transfer with the oldest flags still due.
// ----------------------------------------------------------------------------
module bnpf_checker
  import bnpf_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_W-1:0]              cfg_wdata,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic [IN_IDX_W-1:0]           in_row,
  input  wire logic [IN_IDX_W-1:0]           in_col,
  input  wire logic signed [IN_PAYOFF_W-1:0] in_payoff_row_player,
  input  wire logic signed [IN_PAYOFF_W-1:0] in_payoff_col_player,
  input  wire logic                          in_last_cell,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic [IN_IDX_W-1:0]           out_cell_row,
  input  wire logic [IN_IDX_W-1:0]           out_cell_col,
  input  wire logic                          out_is_nash,
  input  wire logic                          out_is_pareto,
  input  wire logic                          out_last_result,
  output int                                 fail_count,
  output int                                 pending
);

  typedef struct packed {
    idx_t cell_row;
    idx_t cell_col;
    logic nash;
    logic pareto;
    logic tail;
  } cell_flags_t;

  payoff_t          row_pay [MAX_STRATEGIES][MAX_STRATEGIES];
  payoff_t          col_pay [MAX_STRATEGIES][MAX_STRATEGIES];
  idx_t             best_row [MAX_STRATEGIES];
  idx_t             best_col [MAX_STRATEGIES];
  logic [CFG_W-1:0] size_code;
  cell_flags_t      flags_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    size_code  = 4'd8;
  end

  task automatic report(input string what, input int seen, input int due);
    $display("checker: %s mismatch, seen %0d due %0d at %0t", what, seen, due, $time);
    fail_count++;
  endtask

  task automatic analyse_board();
    int          n;
    int          best;
    bit          dominated;
    cell_flags_t f;
    n = (size_code == '0) ? 1 :
        (int'(size_code) > MAX_STRATEGIES) ? MAX_STRATEGIES : int'(size_code);
    for (int j = 0; j < n; j++) begin
      best = 0;
      for (int i = 1; i < n; i++) begin
        if (row_pay[i][j] > row_pay[best][j]) best = i;
      end
      best_row[j] = idx_t'(best);
    end
    for (int i = 0; i < n; i++) begin
      best = 0;
      for (int j = 1; j < n; j++) begin
        if (col_pay[i][j] > col_pay[i][best]) best = j;
      end
      best_col[i] = idx_t'(best);
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        dominated = 1'b0;
        for (int k = 0; k < n; k++) begin
          for (int l = 0; l < n; l++) begin
            if (!(k == i && l == j) && row_pay[k][l] >= row_pay[i][j] &&
                col_pay[k][l] >= col_pay[i][j]) begin
              dominated = 1'b1;
            end
          end
        end
        f.cell_row = idx_t'(i);
        f.cell_col = idx_t'(j);
        f.nash     = (best_row[j] == idx_t'(i)) && (best_col[i] == idx_t'(j));
        f.pareto   = !dominated;
        f.tail     = (i == n - 1) && (j == n - 1);
        flags_due.insert(flags_due.size(), f);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    cell_flags_t due;
    if (!rst_n) begin
      size_code = 4'd8;
      flags_due.delete();
      for (int k = 0; k < MAX_STRATEGIES; k++) begin
        best_row[k] = '0;
        best_col[k] = '0;
      end
    end else begin
      if (cfg_we) size_code = cfg_wdata;
      if (in_valid && !in_stall) begin
        row_pay[in_row][in_col] = payoff_t'(in_payoff_row_player);
        col_pay[in_row][in_col] = payoff_t'(in_payoff_col_player);
        if (in_last_cell) analyse_board();
      end
      if (out_valid && !out_stall) begin
        if (flags_due.size() == 0) begin
          report("unexpected result at cell_row", out_cell_row, -1);
        end else begin
          due = flags_due.pop_front();
          if (out_cell_row != due.cell_row) report("cell_row", out_cell_row, due.cell_row);
          if (out_cell_col != due.cell_col) report("cell_col", out_cell_col, due.cell_col);
          if (out_is_nash != due.nash) report("is_nash", out_is_nash, due.nash);
          if (out_is_pareto != due.pareto) report("is_pareto", out_is_pareto, due.pareto);
          if (out_last_result != due.tail) report("last_result", out_last_result, due.tail);
        end
      end
    end
    pending = flags_due.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the bimatrix Nash/Pareto finder
// Directed boards of sizes 1 to 3 with extreme and tied payoffs, then random
// full loads, partial reloads and loose cells over size codes 0 to 15, with random
// idling on both channels. Results are checked by bnpf_checker.
// ----------------------------------------------------------------------------
module testbench
  import bnpf_pkg::*;
();

  localparam int GAP_MAX      = 13;
  localparam int SETTLE       = 4;
  localparam int DRAIN_CYCLES = 200;
  localparam int CELL_TARGET  = 440;

  typedef enum int {PAY_WIDE, PAY_NARROW, PAY_CORNER} pay_style_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [CFG_W-1:0]              cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic [IN_IDX_W-1:0]           in_row;
  logic [IN_IDX_W-1:0]           in_col;
  logic signed [IN_PAYOFF_W-1:0] in_payoff_row_player;
  logic signed [IN_PAYOFF_W-1:0] in_payoff_col_player;
  logic                          in_last_cell;
  logic                          out_valid;
  logic                          out_stall;
  logic [IN_IDX_W-1:0]           out_cell_row;
  logic [IN_IDX_W-1:0]           out_cell_col;
  logic                          out_is_nash;
  logic                          out_is_pareto;
  logic                          out_last_result;
  int                            fail_count;
  int                            pending;

  bit                            calm;
  bit                            loaded [MAX_STRATEGIES][MAX_STRATEGIES];
  int                            cells_sent;
  int                            cur_n;
  logic [15:0]                   corner_pay [5] = '{16'h8000, 16'hFFFF, 16'h0000,
                                                    16'h0001, 16'h7FFF};

  bimatrix_nash_pareto_finder_top i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_row               (in_row),
    .in_col               (in_col),
    .in_payoff_row_player (in_payoff_row_player),
    .in_payoff_col_player (in_payoff_col_player),
    .in_last_cell         (in_last_cell),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_cell_row         (out_cell_row),
    .out_cell_col         (out_cell_col),
    .out_is_nash          (out_is_nash),
    .out_is_pareto        (out_is_pareto),
    .out_last_result      (out_last_result)
  );

  bnpf_checker i_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_row               (in_row),
    .in_col               (in_col),
    .in_payoff_row_player (in_payoff_row_player),
    .in_payoff_col_player (in_payoff_col_player),
    .in_last_cell         (in_last_cell),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_cell_row         (out_cell_row),
    .out_cell_col         (out_cell_col),
    .out_is_nash          (out_is_nash),
    .out_is_pareto        (out_is_pareto),
    .out_last_result      (out_last_result),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #120_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // result side: per result, hold stall for a drawn number of cycles
  initial begin : sink
    int hold;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, GAP_MAX);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [15:0] draw_payoff(pay_style_t style);
    int v;
    case (style)
      PAY_NARROW: begin
        v = $urandom_range(0, 6);
        return 16'(v - 3);
      end
      PAY_CORNER: return corner_pay[$urandom_range(0, 4)];
      default:    return 16'($urandom);
    endcase
  endfunction

  function automatic bit board_ready(int n);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (!loaded[i][j]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic send_cell(input int r, input int c, input logic [15:0] pr,
                           input logic [15:0] pc, input bit last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_row               <= 3'(r);
    in_col               <= 3'(c);
    in_payoff_row_player <= pr;
    in_payoff_col_player <= pc;
    in_last_cell         <= last;
    do @(posedge clk); while (in_stall);
    loaded[r][c] = 1'b1;
    cells_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] code);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_n = (code == '0) ? 1 : (int'(code) > MAX_STRATEGIES) ? MAX_STRATEGIES : int'(code);
  endtask

  // every cell of the n by n board in shuffled order, last_cell on the final one
  task automatic load_board(input int n, input pay_style_t style, input bit noisy);
    int order [CELLS];
    int pick;
    int tmp;
    for (int k = 0; k < n * n; k++) order[k] = k;
    for (int k = n * n - 1; k > 0; k--) begin
      pick = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[pick];
      order[pick] = tmp;
    end
    for (int k = 0; k < n * n; k++) begin
      if (noisy && $urandom_range(0, 5) == 0) begin
        send_cell($urandom_range(0, 7), $urandom_range(0, 7), draw_payoff(style),
                  draw_payoff(style), 1'b0);
      end
      send_cell(order[k] / n, order[k] % n, draw_payoff(style), draw_payoff(style),
                k == n * n - 1);
    end
  endtask

  // a few rewrites on a board already filled, then analysis
  task automatic patch_board(input int n, input pay_style_t style);
    int cnt;
    int r;
    int c;
    cnt = $urandom_range(1, n);
    for (int k = 0; k < cnt; k++) begin
      r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, n - 1);
      c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, n - 1);
      send_cell(r, c, draw_payoff(style), draw_payoff(style), k == cnt - 1);
    end
  endtask

  function automatic logic [CFG_W-1:0] draw_size_code();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return 4'd0;
    if (pick < 30) return 4'($urandom_range(1, 2));
    if (pick < 65) return 4'($urandom_range(3, 4));
    if (pick < 82) return 4'($urandom_range(5, 6));
    if (pick < 92) return 4'($urandom_range(7, 8));
    return 4'($urandom_range(9, 15));
  endfunction

  initial begin : source
    int         roll;
    int         cnt;
    int         at;
    pay_style_t style;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    in_valid             = 1'b0;
    in_row               = '0;
    in_col               = '0;
    in_payoff_row_player = '0;
    in_payoff_col_player = '0;
    in_last_cell         = 1'b0;
    calm                 = 1'b0;
    cells_sent           = 0;
    cur_n                = MAX_STRATEGIES;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // size code 0 acts as one strategy
    set_size(4'd0);
    send_cell(0, 0, 16'h7FFF, 16'h8000, 1'b1);
    // last cell outside the board in use
    set_size(4'd1);
    send_cell(7, 7, 16'h8000, 16'h7FFF, 1'b1);
    // identical cells: ties to lowest index, no Pareto cell
    set_size(4'd2);
    send_cell(1, 1, 16'd5, 16'd5, 1'b0);
    send_cell(0, 1, 16'd5, 16'd5, 1'b0);
    send_cell(1, 0, 16'd5, 16'd5, 1'b0);
    send_cell(0, 0, 16'd5, 16'd5, 1'b1);
    send_cell(0, 0, 16'h8000, 16'h8000, 1'b0);
    send_cell(1, 1, 16'h7FFF, 16'h7FFF, 1'b1);
    set_size(4'd3);
    send_cell(5, 6, 16'h7FFF, 16'h7FFF, 1'b0);
    send_cell(6, 5, 16'h8000, 16'h8000, 1'b0);
    for (int k = 0; k < 9; k++) begin
      at = (k + 5) % 9;
      send_cell(at / 3, at % 3, corner_pay[k % 5], corner_pay[(k * 3) % 5], k == 8);
    end

    // codes above the maximum act as the full board
    set_size(4'd15);
    load_board(cur_n, PAY_WIDE, 1'b1);

    while (cells_sent < CELL_TARGET) begin
      if ($urandom_range(0, 2) == 0) set_size(draw_size_code());
      calm  = ($urandom_range(0, 4) == 0);
      style = pay_style_t'($urandom_range(0, 2));
      roll  = $urandom_range(0, 9);
      if (!board_ready(cur_n) || roll < 4) begin
        load_board(cur_n, style, roll == 0);
      end else if (roll < 8) begin
        patch_board(cur_n, style);
      end else begin
        cnt = $urandom_range(1, 4);
        for (int k = 0; k < cnt; k++) begin
          send_cell($urandom_range(0, 7), $urandom_range(0, 7), draw_payoff(style),
                    draw_payoff(style), 1'b0);
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
